[design/lookat_view_matrix_unit_macros.svh]
// Assertion macros shared by the look-at view matrix unit
`ifndef LOOKAT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOKAT_VIEW_MATRIX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lvm check failed");
`define LVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lvm check failed");
`else
`define LVM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/lvm_pkg.sv]
// Shared types and constants of the look-at view matrix unit
`timescale 1ns / 1ps
package lvm_pkg;
    typedef logic signed [15:0] q14_t;
    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] cross_t;

    localparam int   FRAC_BITS   = 14;
    localparam int   AXIS_ONE    = 16384;
    localparam q14_t Q14_MIN     = 16'sh8000;
    localparam q14_t Q14_MAX     = 16'sh7fff;

    localparam int SQRT_STAGES = 8;
    localparam int SQRT_STEPS  = 4;
    localparam int DIV_STAGES  = 5;
    localparam int DIV_STEPS   = 3;

    localparam int CROSS_LAT = 2;
    localparam int NORM_LAT  = SQRT_STAGES + DIV_STAGES + 5;
    localparam int DOT_LAT   = 4;

    // rows whose dot product is negated: side and true up
    localparam logic [2:0] DOT_NEGATE = 3'b011;
endpackage

[design/lvm_delay.sv]
// Enable-gated delay line for payload aligned to the arithmetic pipeline
`timescale 1ns / 1ps
module lvm_delay #(
    parameter int W     = 16,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

[design/lvm_cross.sv]
// Two-stage cross product of Q1.14 vectors
`timescale 1ns / 1ps
module lvm_cross import lvm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  q14_t   a [3],
    input  q14_t   b [3],
    output logic   out_valid,
    output cross_t c [3]
);
    logic               v_prod_reg, v_diff_reg;
    logic signed [31:0] pa_reg [3];
    logic signed [31:0] pb_reg [3];
    cross_t             c_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_prod_reg <= 1'b0;
            v_diff_reg <= 1'b0;
        end else if (en) begin
            v_prod_reg <= in_valid;
            v_diff_reg <= v_prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg[0] <= 32'(a[1]) * 32'(b[2]);
            pb_reg[0] <= 32'(a[2]) * 32'(b[1]);
            pa_reg[1] <= 32'(a[2]) * 32'(b[0]);
            pb_reg[1] <= 32'(a[0]) * 32'(b[2]);
            pa_reg[2] <= 32'(a[0]) * 32'(b[1]);
            pb_reg[2] <= 32'(a[1]) * 32'(b[0]);
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= 33'(pa_reg[i]) - 33'(pb_reg[i]);
            end
        end
    end

    assign out_valid = v_diff_reg;
    assign c         = c_reg;
endmodule

[design/lvm_norm.sv]
// Pipelined normalize: sum of squares, digit-by-digit square root, restoring divide
`timescale 1ns / 1ps
module lvm_norm import lvm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  cross_t c [3],
    output logic   out_valid,
    output q14_t   n [3]
);
    localparam int ROOT_W = 32;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 4;
    localparam int NUM_W  = ROOT_W + FRAC_BITS;
    localparam int QUOT_W = DIV_STAGES * DIV_STEPS;
    localparam int DREM_W = ROOT_W + 1;

    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][ROOT_W-1:0] mag;
    } meta_t;

    // magnitude and square stages
    logic             v_mag_reg, v_sq_reg;
    meta_t            meta_mag_reg, meta_sq_reg;
    logic [RAD_W-1:0] sq_reg  [3];
    meta_t            meta_next;
    logic [RAD_W-1:0] sq_next [3];
    logic [RAD_W-1:0] sum_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            meta_next.neg[i] = c[i][ROOT_W];
            meta_next.mag[i] = c[i][ROOT_W] ? ROOT_W'(-c[i]) : c[i][ROOT_W-1:0];
            sq_next[i] = RAD_W'(meta_mag_reg.mag[i]) * RAD_W'(meta_mag_reg.mag[i]);
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    // square root pipeline, entry 0 holds the sum of squares
    logic              sv_reg    [SQRT_STAGES+1];
    meta_t             smeta_reg [SQRT_STAGES+1];
    logic [RAD_W-1:0]  rad_reg   [SQRT_STAGES+1];
    logic [REM_W-1:0]  rem_reg   [SQRT_STAGES+1];
    logic [ROOT_W-1:0] root_reg  [SQRT_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_mag_reg <= 1'b0;
            v_sq_reg  <= 1'b0;
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            v_mag_reg <= in_valid;
            v_sq_reg  <= v_mag_reg;
            sv_reg[0] <= v_sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_mag_reg <= meta_next;
            meta_sq_reg  <= meta_mag_reg;
            sq_reg       <= sq_next;
            smeta_reg[0] <= meta_sq_reg;
            rad_reg[0]   <= sum_next;
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
        end
    end

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        logic [RAD_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [REM_W-1:0]  trial;

        always_comb begin
            rad_next  = rad_reg[g];
            rem_next  = rem_reg[g];
            root_next = root_reg[g];
            trial     = '0;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
                rad_next = {rad_next[RAD_W-3:0], 2'b00};
                trial    = REM_W'({root_next, 2'b01});
                if (rem_next >= trial) begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[ROOT_W-2:0], 1'b1};
                end else begin
                    root_next = {root_next[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[g+1] <= 1'b0;
            end else if (en) begin
                sv_reg[g+1] <= sv_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                smeta_reg[g+1] <= smeta_reg[g];
                rad_reg[g+1]   <= rad_next;
                rem_reg[g+1]   <= rem_next;
                root_reg[g+1]  <= root_next;
            end
        end
    end

    // divide pipeline, entry 0 holds the rounded numerators
    logic              dv_reg    [DIV_STAGES+1];
    logic [2:0]        dneg_reg  [DIV_STAGES+1];
    logic              dzero_reg [DIV_STAGES+1];
    logic [ROOT_W-1:0] dlen_reg  [DIV_STAGES+1];
    logic [DREM_W-1:0] drem_reg  [DIV_STAGES+1][3];
    logic [QUOT_W-1:0] dlow_reg  [DIV_STAGES+1][3];
    logic [QUOT_W-1:0] dquo_reg  [DIV_STAGES+1][3];
    logic [NUM_W-1:0]  num_next  [3];
    logic [ROOT_W-1:0] len;

    assign len = root_reg[SQRT_STAGES];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = {smeta_reg[SQRT_STAGES].mag[i], {FRAC_BITS{1'b0}}}
                        + NUM_W'(len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= sv_reg[SQRT_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dneg_reg[0]  <= smeta_reg[SQRT_STAGES].neg;
            dzero_reg[0] <= (len == '0);
            dlen_reg[0]  <= len;
            for (int i = 0; i < 3; i++) begin
                // the quotient never exceeds one, so the upper part stays below len
                drem_reg[0][i] <= DREM_W'(num_next[i][NUM_W-1:QUOT_W]);
                dlow_reg[0][i] <= num_next[i][QUOT_W-1:0];
                dquo_reg[0][i] <= '0;
            end
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [DREM_W-1:0] rem_next [3];
        logic [QUOT_W-1:0] low_next [3];
        logic [QUOT_W-1:0] quo_next [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem_next[i] = drem_reg[g][i];
                low_next[i] = dlow_reg[g][i];
                quo_next[i] = dquo_reg[g][i];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    rem_next[i] = {rem_next[i][DREM_W-2:0], low_next[i][QUOT_W-1]};
                    low_next[i] = {low_next[i][QUOT_W-2:0], 1'b0};
                    if (rem_next[i] >= DREM_W'(dlen_reg[g])) begin
                        rem_next[i] = rem_next[i] - DREM_W'(dlen_reg[g]);
                        quo_next[i] = {quo_next[i][QUOT_W-2:0], 1'b1};
                    end else begin
                        quo_next[i] = {quo_next[i][QUOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[g+1] <= 1'b0;
            end else if (en) begin
                dv_reg[g+1] <= dv_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dneg_reg[g+1]  <= dneg_reg[g];
                dzero_reg[g+1] <= dzero_reg[g];
                dlen_reg[g+1]  <= dlen_reg[g];
                drem_reg[g+1]  <= rem_next;
                dlow_reg[g+1]  <= low_next;
                dquo_reg[g+1]  <= quo_next;
            end
        end
    end

    // clamp, sign and zero-length handling
    logic              v_out_reg;
    q14_t              n_reg  [3];
    q14_t              n_next [3];
    logic [QUOT_W-1:0] quo_clamp [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quo_clamp[i] = (dquo_reg[DIV_STAGES][i] > QUOT_W'(AXIS_ONE))
                         ? QUOT_W'(AXIS_ONE) : dquo_reg[DIV_STAGES][i];
            if (dzero_reg[DIV_STAGES]) begin
                n_next[i] = '0;
            end else if (dneg_reg[DIV_STAGES][i]) begin
                n_next[i] = -q14_t'({1'b0, quo_clamp[i]});
            end else begin
                n_next[i] = q14_t'({1'b0, quo_clamp[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_out_reg <= dv_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
        end
    end

    assign out_valid = v_out_reg;
    assign n         = n_reg;
endmodule

[design/lvm_dot.sv]
// Translation terms: three dot products with rounding, sign and saturation
`timescale 1ns / 1ps
module lvm_dot import lvm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  q14_t side [3],
    input  q14_t tup  [3],
    input  q14_t look [3],
    input  q16_t eye  [3],
    output logic out_valid,
    output q16_t shift [3]
);
    localparam int PROD_W = 48;
    localparam int ACC_W  = PROD_W + 2;
    localparam int M_W    = ACC_W - FRAC_BITS;

    q14_t                     row      [3][3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic [ACC_W-1:0]         mag_reg  [3];
    logic [2:0]               neg_reg;
    q16_t                     shift_reg  [3];
    q16_t                     shift_next [3];
    logic [M_W-1:0]           rnd        [3];
    logic                     res_neg    [3];
    logic                     v_prod_reg, v_acc_reg, v_mag_reg, v_out_reg;

    assign row[0] = side;
    assign row[1] = tup;
    assign row[2] = look;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rnd[r]     = M_W'((mag_reg[r] + ACC_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            res_neg[r] = neg_reg[r] ^ DOT_NEGATE[r];
            if (res_neg[r]) begin
                shift_next[r] = (rnd[r] > M_W'(33'h080000000)) ? q16_t'(32'sh80000000)
                              : -q16_t'(rnd[r][31:0]);
            end else begin
                shift_next[r] = (rnd[r] > M_W'(32'h7fffffff)) ? q16_t'(32'sh7fffffff)
                              : q16_t'(rnd[r][31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_prod_reg <= 1'b0;
            v_acc_reg  <= 1'b0;
            v_mag_reg  <= 1'b0;
            v_out_reg  <= 1'b0;
        end else if (en) begin
            v_prod_reg <= in_valid;
            v_acc_reg  <= v_prod_reg;
            v_mag_reg  <= v_acc_reg;
            v_out_reg  <= v_mag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    prod_reg[r][i] <= PROD_W'(row[r][i]) * PROD_W'(eye[i]);
                end
                acc_reg[r] <= ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                            + ACC_W'(prod_reg[r][2]);
                neg_reg[r] <= acc_reg[r][ACC_W-1];
                mag_reg[r] <= acc_reg[r][ACC_W-1] ? ACC_W'(-acc_reg[r]) : ACC_W'(acc_reg[r]);
            end
            shift_reg <= shift_next;
        end
    end

    assign out_valid = v_out_reg;
    assign shift     = shift_reg;
endmodule

[design/lookat_view_matrix_unit.sv]
// Top level of the look-at view matrix unit
`timescale 1ns / 1ps
`include "lookat_view_matrix_unit_macros.svh"
// Takes one camera (look, up hint, eye) per cycle and returns its view matrix rows
// and translation: two cross products, two normalize pipelines (each with 8
// square-root stages of 4 root bits and 5 divide stages of 3 quotient bits) and
// the dot products. The whole pipeline advances together; s_ready is high
// whenever the output register is empty or being taken, so a steady stream runs
// at one request per cycle while m_ready stays high.
module lookat_view_matrix_unit import lvm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  q14_t s_look_x,
    input  q14_t s_look_y,
    input  q14_t s_look_z,
    input  q14_t s_up_hint_x,
    input  q14_t s_up_hint_y,
    input  q14_t s_up_hint_z,
    input  q16_t s_eye_x,
    input  q16_t s_eye_y,
    input  q16_t s_eye_z,
    output logic m_valid,
    input  logic m_ready,
    output q14_t m_side_x,
    output q14_t m_side_y,
    output q14_t m_side_z,
    output q14_t m_true_up_x,
    output q14_t m_true_up_y,
    output q14_t m_true_up_z,
    output q14_t m_back_x,
    output q14_t m_back_y,
    output q14_t m_back_z,
    output q16_t m_shift_x,
    output q16_t m_shift_y,
    output q16_t m_shift_z
);
    localparam int HALF_LAT = CROSS_LAT + NORM_LAT;

    logic   en;
    q14_t   look_in [3];
    q14_t   up_in   [3];
    q14_t   back_in [3];
    cross_t c1 [3];
    cross_t c2 [3];
    q14_t   side_n  [3];
    q14_t   tup_n   [3];
    q14_t   look_d1 [3];
    q14_t   look_d2 [3];
    q14_t   side_a  [3];
    q16_t   eye_in  [3];
    q16_t   eye_d   [3];
    q16_t   shift   [3];
    logic   v_c1, v_s, v_c2, v_t, v_out;

    logic [47:0] look_d1_bus, look_d2_bus, side_a_bus, back_bus;
    logic [95:0] eye_bus, rows_bus;

    // hold the whole pipeline while a finished result waits
    assign en      = !v_out || m_ready;
    assign s_ready = en;

    assign look_in = '{s_look_x, s_look_y, s_look_z};
    assign up_in   = '{s_up_hint_x, s_up_hint_y, s_up_hint_z};
    assign eye_in  = '{s_eye_x, s_eye_y, s_eye_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            back_in[i] = (look_in[i] == Q14_MIN) ? Q14_MAX : -look_in[i];
        end
    end

    lvm_cross u_cross_side (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .a(look_in), .b(up_in), .out_valid(v_c1), .c(c1)
    );

    lvm_norm u_norm_side (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_c1),
        .c(c1), .out_valid(v_s), .n(side_n)
    );

    lvm_delay #(.W(48), .DEPTH(HALF_LAT)) u_look_d1 (
        .aclk(aclk), .en(en),
        .d({look_in[2], look_in[1], look_in[0]}), .q(look_d1_bus)
    );

    assign look_d1 = '{look_d1_bus[15:0], look_d1_bus[31:16], look_d1_bus[47:32]};

    lvm_cross u_cross_up (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_s),
        .a(side_n), .b(look_d1), .out_valid(v_c2), .c(c2)
    );

    lvm_norm u_norm_up (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_c2),
        .c(c2), .out_valid(v_t), .n(tup_n)
    );

    lvm_delay #(.W(48), .DEPTH(HALF_LAT)) u_look_d2 (
        .aclk(aclk), .en(en), .d(look_d1_bus), .q(look_d2_bus)
    );

    lvm_delay #(.W(48), .DEPTH(HALF_LAT)) u_side_d (
        .aclk(aclk), .en(en),
        .d({side_n[2], side_n[1], side_n[0]}), .q(side_a_bus)
    );

    lvm_delay #(.W(96), .DEPTH(2 * HALF_LAT)) u_eye_d (
        .aclk(aclk), .en(en),
        .d({eye_in[2], eye_in[1], eye_in[0]}), .q(eye_bus)
    );

    assign look_d2 = '{look_d2_bus[15:0], look_d2_bus[31:16], look_d2_bus[47:32]};
    assign side_a  = '{side_a_bus[15:0], side_a_bus[31:16], side_a_bus[47:32]};
    assign eye_d   = '{eye_bus[31:0], eye_bus[63:32], eye_bus[95:64]};

    lvm_dot u_dot (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_t),
        .side(side_a), .tup(tup_n), .look(look_d2), .eye(eye_d),
        .out_valid(v_out), .shift(shift)
    );

    lvm_delay #(.W(96), .DEPTH(DOT_LAT)) u_rows_d (
        .aclk(aclk), .en(en),
        .d({tup_n[2], tup_n[1], tup_n[0], side_a_bus}), .q(rows_bus)
    );

    lvm_delay #(.W(48), .DEPTH(2 * HALF_LAT + DOT_LAT)) u_back_d (
        .aclk(aclk), .en(en),
        .d({back_in[2], back_in[1], back_in[0]}), .q(back_bus)
    );

    assign m_valid     = v_out;
    assign m_side_x    = rows_bus[15:0];
    assign m_side_y    = rows_bus[31:16];
    assign m_side_z    = rows_bus[47:32];
    assign m_true_up_x = rows_bus[63:48];
    assign m_true_up_y = rows_bus[79:64];
    assign m_true_up_z = rows_bus[95:80];
    assign m_back_x    = back_bus[15:0];
    assign m_back_y    = back_bus[31:16];
    assign m_back_z    = back_bus[47:32];
    assign m_shift_x   = shift[0];
    assign m_shift_y   = shift[1];
    assign m_shift_z   = shift[2];

    `LVM_ASSERT_NOW(a_side_range, aclk, aresetn, m_valid, (m_side_x >= -AXIS_ONE && m_side_x <= AXIS_ONE && m_side_y >= -AXIS_ONE && m_side_y <= AXIS_ONE && m_side_z >= -AXIS_ONE && m_side_z <= AXIS_ONE))
    `LVM_ASSERT_NOW(a_up_range, aclk, aresetn, m_valid, (m_true_up_x >= -AXIS_ONE && m_true_up_x <= AXIS_ONE && m_true_up_y >= -AXIS_ONE && m_true_up_y <= AXIS_ONE && m_true_up_z >= -AXIS_ONE && m_true_up_z <= AXIS_ONE))
    `LVM_ASSERT_NOW(a_zero_side, aclk, aresetn, (m_valid && m_side_x == 0 && m_side_y == 0 && m_side_z == 0), (m_true_up_x == 0 && m_true_up_y == 0 && m_true_up_z == 0))
    `LVM_ASSERT_NEXT(a_frozen, aclk, aresetn, !s_ready, ($stable(m_side_x) && $stable(m_true_up_y) && $stable(m_back_z) && $stable(m_shift_z)))
endmodule
